// ----- src/rsh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsh_pkg
// Shared types and codes of the running statistics histogram block.
// ----------------------------------------------------------------------------
package rsh_pkg;

	// request kinds
	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REPORT = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;
	localparam logic [1:0] KIND_BIN    = 2'd3;

	// result status codes
	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_EMPTY   = 3'd1;
	localparam logic [2:0] STS_MEANZ   = 3'd2;
	localparam logic [2:0] STS_DROPPED = 3'd3;
	localparam logic [2:0] STS_BADBIN  = 3'd4;

	localparam logic [22:0] SD_MAX = 23'h7FFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_RPT,
		ST_CLR,
		ST_BIN
	} top_state_t;

	typedef enum logic [2:0] {
		RS_IDLE,
		RS_MEAN,
		RS_MUL1,
		RS_MUL2,
		RS_SUB,
		RS_VDIV,
		RS_SQRT,
		RS_CV
	} rep_state_t;

	typedef struct packed {
		logic start;
		logic ack;
	} rep_ctl_t;

	typedef struct packed {
		logic        done;
		logic [2:0]  status;
		logic [23:0] mean;
		logic [22:0] std_dev;
		logic [31:0] coeff_var;
	} rep_res_t;

endpackage

// ----- src/running_stats_histogram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_stats_histogram
// Running count, mean, standard deviation, min, max and integer-bin
// histogram of signed Q12.12 samples.
// ----------------------------------------------------------------------------
// One request is worked at a time and gives one result. For an add or a
// bin read the histogram RAM is read in the accept cycle; an add writes the
// incremented count back once the output register is free. A report runs
// in the bit-serial divider, shift-add multiplier and square root of the
// report engine. A finished result waits in the output register while the
// next request is taken. Histogram entries carry valid bits, so clear is
// immediate.
// ----------------------------------------------------------------------------
module running_stats_histogram #(
	parameter int NUM_BINS  = 50,
	parameter int MAX_COUNT = 65535
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         kind,
	input  logic signed [23:0] sample,
	input  logic [5:0]         bin_index,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [2:0]         status,
	output logic [15:0]        count,
	output logic signed [23:0] mean_value,
	output logic [22:0]        std_dev,
	output logic signed [31:0] coeff_var,
	output logic signed [23:0] minimum,
	output logic signed [23:0] maximum,
	output logic [15:0]        bin_count
);

	localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

	rsh_pkg::top_state_t state_q, state_d;
	rsh_pkg::rep_ctl_t   rep_ctl;
	rsh_pkg::rep_res_t   rep_res;

	logic [15:0]        count_q;
	logic signed [39:0] sum_q;
	logic [63:0]        sumsq_q;
	logic signed [23:0] min_q;
	logic signed [23:0] max_q;
	logic [NUM_BINS-1:0] valid_q;

	logic signed [23:0] samp_s1;
	logic [47:0]        sq_s1;
	logic [AW-1:0]      addr_s1;
	logic               hit_s1;
	logic               vld_s1;

	logic               out_valid_q;
	logic [2:0]         status_q;
	logic [15:0]        cnt_out_q;
	logic [23:0]        mean_q;
	logic [22:0]        sd_q;
	logic [31:0]        cv_q;
	logic [23:0]        min_out_q;
	logic [23:0]        max_out_q;
	logic [15:0]        bin_q;

	logic          accept;
	logic          out_free;
	logic          finish;
	logic          full;
	logic          add_hit;
	logic          rd_hit;
	logic          hit;
	logic [AW-1:0] raddr;
	logic          ram_we;
	logic [15:0]   ram_rdata;
	logic [15:0]   bin_val;

	assign accept   = req_valid && !req_stall;
	assign out_free = !out_valid_q || !rsp_stall;
	assign full     = (count_q >= 16'(MAX_COUNT));
	assign add_hit  = !sample[23] && (sample[22:12] < 11'(NUM_BINS));
	assign rd_hit   = ({1'b0, bin_index} < 7'(NUM_BINS));
	assign hit      = (kind == rsh_pkg::KIND_ADD) ? add_hit : rd_hit;
	assign raddr    = (kind == rsh_pkg::KIND_ADD) ? sample[12 +: AW] : bin_index[AW-1:0];
	assign bin_val  = vld_s1 ? ram_rdata : 16'd0;
	assign ram_we   = (state_q == rsh_pkg::ST_ADD) && out_free && !full && hit_s1;

	rsh_ram #(
		.WIDTH (16),
		.DEPTH (NUM_BINS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (bin_val + 16'd1),
		.re    (accept),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	rsh_report u_report (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rep_ctl),
		.n      (count_q),
		.sum    (sum_q),
		.sum_sq (sumsq_q),
		.res    (rep_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsh_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						rsh_pkg::KIND_ADD:    state_d = rsh_pkg::ST_ADD;
						rsh_pkg::KIND_REPORT: state_d = rsh_pkg::ST_RPT;
						rsh_pkg::KIND_CLEAR:  state_d = rsh_pkg::ST_CLR;
						rsh_pkg::KIND_BIN:    state_d = rsh_pkg::ST_BIN;
						default:              state_d = rsh_pkg::ST_IDLE;
					endcase
				end
			end
			rsh_pkg::ST_ADD, rsh_pkg::ST_CLR, rsh_pkg::ST_BIN: begin
				if (out_free) state_d = rsh_pkg::ST_IDLE;
			end
			rsh_pkg::ST_RPT: begin
				if (rep_res.done && out_free) state_d = rsh_pkg::ST_IDLE;
			end
			default: state_d = rsh_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_stall     = (state_q != rsh_pkg::ST_IDLE);
		rep_ctl.start = 1'b0;
		rep_ctl.ack   = 1'b0;
		finish        = 1'b0;
		unique case (state_q)
			rsh_pkg::ST_IDLE: begin
				rep_ctl.start = req_valid && (kind == rsh_pkg::KIND_REPORT);
			end
			rsh_pkg::ST_ADD, rsh_pkg::ST_CLR, rsh_pkg::ST_BIN: begin
				finish = out_free;
			end
			rsh_pkg::ST_RPT: begin
				finish      = rep_res.done && out_free;
				rep_ctl.ack = finish;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rsh_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= 16'd0;
			sum_q       <= 40'sd0;
			sumsq_q     <= 64'd0;
			min_q       <= 24'sd0;
			max_q       <= 24'sd0;
			valid_q     <= '0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept && kind == rsh_pkg::KIND_CLEAR) begin
				count_q <= 16'd0;
				sum_q   <= 40'sd0;
				sumsq_q <= 64'd0;
				min_q   <= 24'sd0;
				max_q   <= 24'sd0;
				valid_q <= '0;
			end
			if (state_q == rsh_pkg::ST_ADD && out_free && !full) begin
				count_q <= count_q + 16'd1;
				sum_q   <= sum_q + {{16{samp_s1[23]}}, samp_s1};
				sumsq_q <= sumsq_q + {16'd0, sq_s1};
				if (count_q == 16'd0) begin
					min_q <= samp_s1;
					max_q <= samp_s1;
				end else begin
					if (samp_s1 < min_q) min_q <= samp_s1;
					if (samp_s1 > max_q) max_q <= samp_s1;
				end
				if (hit_s1) valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	// request capture and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			samp_s1 <= sample;
			sq_s1   <= 48'(sample * sample);
			addr_s1 <= raddr;
			hit_s1  <= hit;
			vld_s1  <= hit ? valid_q[raddr] : 1'b0;
		end
		if (finish) begin
			status_q  <= rsh_pkg::STS_OK;
			cnt_out_q <= count_q;
			mean_q    <= 24'd0;
			sd_q      <= 23'd0;
			cv_q      <= 32'd0;
			min_out_q <= 24'd0;
			max_out_q <= 24'd0;
			bin_q     <= 16'd0;
			case (state_q)
				rsh_pkg::ST_ADD: begin
					if (full) begin
						status_q <= rsh_pkg::STS_DROPPED;
					end else begin
						cnt_out_q <= count_q + 16'd1;
					end
				end
				rsh_pkg::ST_BIN: begin
					if (hit_s1) begin
						bin_q <= bin_val;
					end else begin
						status_q <= rsh_pkg::STS_BADBIN;
					end
				end
				rsh_pkg::ST_RPT: begin
					status_q  <= rep_res.status;
					mean_q    <= rep_res.mean;
					sd_q      <= rep_res.std_dev;
					cv_q      <= rep_res.coeff_var;
					min_out_q <= min_q;
					max_out_q <= max_q;
				end
				default: ;
			endcase
		end
	end

	assign rsp_valid  = out_valid_q;
	assign status     = status_q;
	assign count      = cnt_out_q;
	assign mean_value = mean_q;
	assign std_dev    = sd_q;
	assign coeff_var  = cv_q;
	assign minimum    = min_out_q;
	assign maximum    = max_out_q;
	assign bin_count  = bin_q;

endmodule

// ----- src/rsh_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rsh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/rsh_report.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsh_report
// Sequential report engine: mean, sample standard deviation and coefficient
// of variation from the running sums, with one bit-serial divider, one
// shift-add multiplier and one bit-serial square root.
// ----------------------------------------------------------------------------
module rsh_report (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rsh_pkg::rep_ctl_t        ctl,
	input  logic [15:0]              n,
	input  logic signed [39:0]       sum,
	input  logic [63:0]              sum_sq,
	output rsh_pkg::rep_res_t        res
);

	rsh_pkg::rep_state_t state_q, state_d;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [15:0] n_q;
	logic        neg_q;
	logic [39:0] mag_q;
	logic [63:0] s2_q;
	logic [79:0] dv_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic [79:0] acc_q;
	logic [79:0] mc_q;
	logic [39:0] mp_q;
	logic [79:0] p_q;
	logic [63:0] sq_x_q;
	logic [63:0] sq_res_q;
	logic [63:0] sq_bit_q;
	logic        big_q;
	logic [2:0]  status_q;
	logic [23:0] mean_q;
	logic [22:0] sd_q;
	logic [31:0] cv_q;

	logic        last;
	logic [32:0] rem_sh;
	logic        div_ge;
	logic [32:0] rem_nx;
	logic [79:0] dv_nx;
	logic [79:0] acc_nx;
	logic [63:0] sq_t;
	logic        sq_ge;
	logic [63:0] sq_res_nx;
	logic [24:0] mean_up;
	logic [24:0] mean_neg;
	logic [23:0] mean_nx;
	logic [22:0] sd_nx;
	logic [23:0] mean_abs;
	logic [38:0] cv_q39;
	logic [31:0] cv_nx;
	logic [39:0] sum_mag;

	assign last   = (cnt_q == 7'd1);
	assign rem_sh = {rem_q[31:0], dv_q[79]};
	assign div_ge = (rem_sh >= {1'b0, dsr_q});
	assign rem_nx = div_ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	assign dv_nx  = {dv_q[78:0], div_ge};
	assign acc_nx = acc_q + (mp_q[0] ? mc_q : 80'd0);

	assign sq_t      = sq_res_q + sq_bit_q;
	assign sq_ge     = (sq_x_q >= sq_t);
	assign sq_res_nx = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);

	// floor division: round the magnitude up when the sum is negative
	assign mean_up  = {1'b0, dv_nx[23:0]} + {24'd0, |rem_nx};
	assign mean_neg = 25'd0 - mean_up;
	assign mean_nx  = neg_q ? mean_neg[23:0] : dv_nx[23:0];

	assign sd_nx    = (big_q || (|sq_res_nx[63:23])) ? rsh_pkg::SD_MAX : sq_res_nx[22:0];
	assign mean_abs = mean_q[23] ? (24'd0 - mean_q) : mean_q;
	assign cv_q39   = dv_nx[38:0];
	assign sum_mag  = sum[39] ? (40'd0 - sum) : sum;

	always_comb begin
		if (!mean_q[23]) begin
			cv_nx = (|cv_q39[38:31]) ? 32'h7FFFFFFF : cv_q39[31:0];
		end else begin
			cv_nx = (cv_q39 > 39'h80000000) ? 32'h80000000 : (32'd0 - cv_q39[31:0]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsh_pkg::RS_IDLE: begin
				if (ctl.start && n != 16'd0) state_d = rsh_pkg::RS_MEAN;
			end
			rsh_pkg::RS_MEAN: begin
				if (last) state_d = (n_q == 16'd1) ? rsh_pkg::RS_IDLE : rsh_pkg::RS_MUL1;
			end
			rsh_pkg::RS_MUL1: begin
				if (last) state_d = rsh_pkg::RS_MUL2;
			end
			rsh_pkg::RS_MUL2: begin
				if (last) state_d = rsh_pkg::RS_SUB;
			end
			rsh_pkg::RS_SUB: begin
				state_d = rsh_pkg::RS_VDIV;
			end
			rsh_pkg::RS_VDIV: begin
				if (last) state_d = rsh_pkg::RS_SQRT;
			end
			rsh_pkg::RS_SQRT: begin
				if (last) state_d = (mean_q == 24'd0) ? rsh_pkg::RS_IDLE : rsh_pkg::RS_CV;
			end
			rsh_pkg::RS_CV: begin
				if (last) state_d = rsh_pkg::RS_IDLE;
			end
			default: state_d = rsh_pkg::RS_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		res.done      = done_q;
		res.status    = status_q;
		res.mean      = mean_q;
		res.std_dev   = sd_q;
		res.coeff_var = cv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsh_pkg::RS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.ack) begin
				done_q <= 1'b0;
			end else if ((state_q == rsh_pkg::RS_IDLE && ctl.start && n == 16'd0)
				|| (state_d == rsh_pkg::RS_IDLE && state_q != rsh_pkg::RS_IDLE)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q != rsh_pkg::RS_IDLE) begin
			cnt_q <= cnt_q - 7'd1;
		end
		unique case (state_q)
			rsh_pkg::RS_IDLE: begin
				if (ctl.start) begin
					n_q      <= n;
					neg_q    <= sum[39];
					mag_q    <= sum_mag;
					s2_q     <= sum_sq;
					dv_q     <= {sum_mag, 40'd0};
					rem_q    <= 33'd0;
					dsr_q    <= {16'd0, n};
					cnt_q    <= 7'd40;
					big_q    <= 1'b0;
					status_q <= (n == 16'd0) ? rsh_pkg::STS_EMPTY : rsh_pkg::STS_OK;
					mean_q   <= 24'd0;
					sd_q     <= 23'd0;
					cv_q     <= 32'd0;
				end
			end
			rsh_pkg::RS_MEAN: begin
				dv_q  <= dv_nx;
				rem_q <= rem_nx;
				if (last) begin
					mean_q <= mean_nx;
					acc_q  <= 80'd0;
					mc_q   <= {16'd0, s2_q};
					mp_q   <= {24'd0, n_q};
					cnt_q  <= 7'd16;
				end
			end
			rsh_pkg::RS_MUL1: begin
				acc_q <= acc_nx;
				mc_q  <= mc_q << 1;
				mp_q  <= mp_q >> 1;
				if (last) begin
					p_q   <= acc_nx;
					acc_q <= 80'd0;
					mc_q  <= {40'd0, mag_q};
					mp_q  <= mag_q;
					cnt_q <= 7'd40;
				end
			end
			rsh_pkg::RS_MUL2: begin
				acc_q <= acc_nx;
				mc_q  <= mc_q << 1;
				mp_q  <= mp_q >> 1;
			end
			rsh_pkg::RS_SUB: begin
				// clamp a negative variance numerator to zero
				dv_q  <= (p_q >= acc_q) ? (p_q - acc_q) : 80'd0;
				rem_q <= 33'd0;
				dsr_q <= 32'(n_q) * 32'(n_q - 16'd1);
				cnt_q <= 7'd80;
			end
			rsh_pkg::RS_VDIV: begin
				dv_q  <= dv_nx;
				rem_q <= rem_nx;
				if (last) begin
					big_q    <= |dv_nx[79:64];
					sq_x_q   <= dv_nx[63:0];
					sq_res_q <= 64'd0;
					sq_bit_q <= 64'd1 << 62;
					cnt_q    <= 7'd32;
				end
			end
			rsh_pkg::RS_SQRT: begin
				if (sq_ge) sq_x_q <= sq_x_q - sq_t;
				sq_res_q <= sq_res_nx;
				sq_bit_q <= sq_bit_q >> 2;
				if (last) begin
					sd_q <= sd_nx;
					if (mean_q == 24'd0) status_q <= rsh_pkg::STS_MEANZ;
					dv_q  <= {sd_nx, 57'd0};
					rem_q <= 33'd0;
					dsr_q <= {8'd0, mean_abs};
					cnt_q <= 7'd39;
				end
			end
			rsh_pkg::RS_CV: begin
				dv_q  <= dv_nx;
				rem_q <= rem_nx;
				if (last) cv_q <= cv_nx;
			end
			default: ;
		endcase
	end

endmodule

// ----- verif/rsh_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsh_checker
// Watches both channels of the running statistics histogram block, predicts
// one result per accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module rsh_checker #(
	parameter int NUM_BINS  = 50,
	parameter int MAX_COUNT = 65535
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [1:0]         kind,
	input  logic signed [23:0] sample,
	input  logic [5:0]         bin_index,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic [2:0]         status,
	input  logic [15:0]        count,
	input  logic signed [23:0] mean_value,
	input  logic [22:0]        std_dev,
	input  logic signed [31:0] coeff_var,
	input  logic signed [23:0] minimum,
	input  logic signed [23:0] maximum,
	input  logic [15:0]        bin_count,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [2:0]         status;
		logic [15:0]        count;
		logic signed [23:0] mean;
		logic [22:0]        sd;
		logic signed [31:0] cv;
		logic signed [23:0] mn;
		logic signed [23:0] mx;
		logic [15:0]        bin;
	} stats_res_t;

	stats_res_t         expected_q[$];
	logic [15:0]        n_acc;
	logic signed [39:0] sum_acc;
	logic [63:0]        sq_acc;
	logic signed [23:0] lo_acc, hi_acc;
	logic [15:0]        hist[NUM_BINS];
	int                 mismatches = 0;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r, b, x;
		r = '0;
		x = v;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic clear_stats();
		n_acc = '0;
		sum_acc = '0;
		sq_acc = '0;
		lo_acc = '0;
		hi_acc = '0;
		for (int i = 0; i < NUM_BINS; i++) hist[i] = '0;
	endtask

	task automatic predict_stats(input logic [1:0] k, input logic signed [23:0] x,
			input logic [5:0] bi);
		stats_res_t          r;
		logic [63:0]         mag, nn, q;
		logic [127:0]        p, s, d;
		logic signed [63:0]  m, c;
		logic [63:0]         sdv;
		logic signed [47:0]  sq;
		r = '0;
		case (k)
			rsh_pkg::KIND_ADD: begin
				if (n_acc >= MAX_COUNT)
					r.status = rsh_pkg::STS_DROPPED;
				else begin
					n_acc = n_acc + 16'd1;
					if (n_acc == 1) begin
						lo_acc = x;
						hi_acc = x;
					end else begin
						if (x > hi_acc) hi_acc = x;
						if (x < lo_acc) lo_acc = x;
					end
					sum_acc = sum_acc + 40'(x);
					sq = x * x;
					sq_acc = sq_acc + 64'(sq);
					if (x >= 0 && (x >>> 12) < NUM_BINS)
						hist[x >>> 12] = hist[x >>> 12] + 16'd1;
				end
			end
			rsh_pkg::KIND_REPORT: begin
				if (n_acc == 0)
					r.status = rsh_pkg::STS_EMPTY;
				else begin
					nn = 64'(n_acc);
					mag = sum_acc < 0 ? 64'(-sum_acc) : 64'(sum_acc);
					if (sum_acc < 0) m = -$signed((mag + nn - 1) / nn);
					else m = $signed(mag / nn);
					r.mean = m[23:0];
					r.mn = lo_acc;
					r.mx = hi_acc;
					if (nn > 1) begin
						p = 128'(nn) * 128'(sq_acc);
						s = 128'(mag) * 128'(mag);
						d = (p < s) ? 128'd0 : p - s;
						d = d / 128'(nn * (nn - 1));
						q = d[63:0];
						sdv = (d[127:64] != 0) ? 64'h7FFFFF : int_sqrt(q);
						if (sdv > 64'h7FFFFF) sdv = 64'h7FFFFF;
						r.sd = sdv[22:0];
						if (m == 0)
							r.status = rsh_pkg::STS_MEANZ;
						else begin
							c = $signed(sdv << 16) / m;
							if (c > 64'sd2147483647) c = 64'sd2147483647;
							if (c < -64'sd2147483648) c = -64'sd2147483648;
							r.cv = c[31:0];
						end
					end
				end
			end
			rsh_pkg::KIND_CLEAR: clear_stats();
			default: begin
				if (bi >= NUM_BINS) r.status = rsh_pkg::STS_BADBIN;
				else r.bin = hist[bi];
			end
		endcase
		r.count = n_acc;
		expected_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	assign errors = mismatches;

	always @(posedge clk) begin
		stats_res_t e;
		if (!arst_n) begin
			clear_stats();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0)
					report_mismatch("unexpected transfer", 32'(status), 32'd0);
				else begin
					e = expected_q.pop_front();
					if (status !== e.status)
						report_mismatch("status", 32'(status), 32'(e.status));
					if (count !== e.count)
						report_mismatch("count", 32'(count), 32'(e.count));
					if (mean_value !== e.mean)
						report_mismatch("mean", 32'(mean_value), 32'(e.mean));
					if (std_dev !== e.sd)
						report_mismatch("std_dev", 32'(std_dev), 32'(e.sd));
					if (coeff_var !== e.cv)
						report_mismatch("coeff_var", coeff_var, e.cv);
					if (minimum !== e.mn)
						report_mismatch("minimum", 32'(minimum), 32'(e.mn));
					if (maximum !== e.mx)
						report_mismatch("maximum", 32'(maximum), 32'(e.mx));
					if (bin_count !== e.bin)
						report_mismatch("bin_count", 32'(bin_count), 32'(e.bin));
				end
			end
			if (req_valid && !req_stall) predict_stats(kind, sample, bin_index);
		end
		pending = expected_q.size();
	end

endmodule

// ----- verif/tb_running_stats_histogram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_stats_histogram
// Drives directed and random requests (adds, reports, clears, bin reads)
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_running_stats_histogram;

	logic               clk, arst_n;
	logic               req_valid, req_stall, rsp_valid, rsp_stall;
	logic [1:0]         kind;
	logic signed [23:0] sample;
	logic [5:0]         bin_index;
	logic [2:0]         status;
	logic [15:0]        count, bin_count;
	logic signed [23:0] mean_value, minimum, maximum;
	logic [22:0]        std_dev;
	logic signed [31:0] coeff_var;
	int                 errors, pending;
	int                 send_idle, recv_idle;
	int                 quiet = 0;

	localparam int WATCHDOG = 20000;

	running_stats_histogram dut (.*);

	rsh_checker chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// receiver idling
	always @(posedge clk) rsp_stall <= ($urandom_range(99) < recv_idle);

	// end the run as failed if no transfer happens on either channel for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("** running_stats_histogram: FAILED **");
			$finish;
		end
	end

	task automatic send_req(input logic [1:0] k, input logic signed [23:0] x,
			input logic [5:0] bi);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		kind <= k;
		sample <= x;
		bin_index <= bi;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(4))
			0: return $signed(24'($urandom));
			1: return 24'($urandom_range(50 * 4096 - 1));
			2: return -$signed(24'($urandom_range(4096)));
			3: return 24'($urandom_range(4095)) + 24'(1000 * 4096);
			default: return 24'($urandom_range(8192)) - 24'sd4096;
		endcase
	endfunction

	task automatic random_phase(input int items);
		int r;
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(99);
			if (r < 70)
				send_req(rsh_pkg::KIND_ADD, rand_sample(), 6'($urandom));
			else if (r < 80)
				send_req(rsh_pkg::KIND_REPORT, 24'($urandom), 6'($urandom));
			else if (r < 83)
				send_req(rsh_pkg::KIND_CLEAR, 24'($urandom), 6'($urandom));
			else
				send_req(rsh_pkg::KIND_BIN, 24'($urandom), 6'($urandom));
		end
	endtask

	initial begin
		arst_n = 0;
		req_valid = 0;
		kind = rsh_pkg::KIND_ADD;
		sample = 0;
		bin_index = 0;
		send_idle = 25;
		recv_idle = 71;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty report, single sample, extremes, zero mean, bins
		send_req(rsh_pkg::KIND_REPORT, 0, 0);
		send_req(rsh_pkg::KIND_BIN, 0, 63);
		send_req(rsh_pkg::KIND_ADD, 24'sd4096, 0);
		send_req(rsh_pkg::KIND_REPORT, 0, 0);
		send_req(rsh_pkg::KIND_BIN, 0, 1);
		send_req(rsh_pkg::KIND_ADD, -24'sd4096, 0);
		send_req(rsh_pkg::KIND_REPORT, 0, 0);
		send_req(rsh_pkg::KIND_ADD, 24'sh7FFFFF, 0);
		send_req(rsh_pkg::KIND_ADD, -24'sh800000, 0);
		send_req(rsh_pkg::KIND_ADD, 24'sd49 * 4096 + 24'sd4095, 0);
		send_req(rsh_pkg::KIND_ADD, 24'sd50 * 4096, 0);
		send_req(rsh_pkg::KIND_REPORT, 0, 0);
		send_req(rsh_pkg::KIND_BIN, 0, 49);
		send_req(rsh_pkg::KIND_BIN, 0, 50);
		send_req(rsh_pkg::KIND_CLEAR, 0, 0);
		send_req(rsh_pkg::KIND_BIN, 0, 49);
		send_req(rsh_pkg::KIND_ADD, 24'sh7FFFFF, 0);
		send_req(rsh_pkg::KIND_ADD, 24'sh7FFFFF, 0);
		send_req(rsh_pkg::KIND_REPORT, 0, 0);
		send_req(rsh_pkg::KIND_ADD, -24'sh800000, 6'h3F);
		send_req(rsh_pkg::KIND_ADD, -24'sh800000, 6'h3F);
		send_req(rsh_pkg::KIND_REPORT, 24'hFFFFFF, 6'h3F);
		send_req(rsh_pkg::KIND_CLEAR, 24'hFFFFFF, 6'h3F);

		random_phase(480);
		send_idle = 71;
		recv_idle = 25;
		random_phase(480);
		send_idle = 0;
		recv_idle = 0;
		random_phase(480);
		req_valid <= 0;

		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("** running_stats_histogram: PASSED **");
		else
			$display("** running_stats_histogram: FAILED **");
		$finish;
	end

endmodule
